// File: hw/rtl/pmet_pkg.sv
// Shared constants and types of the multi-channel period meter.
`timescale 1ns / 1ps

package pmet_pkg;

    localparam int CHANNEL_COUNT = 4;

    localparam int CH_W       = 2;
    localparam int CAPTURE_W  = 16;
    localparam int STAMP_W    = 32;
    localparam int TICK_INC_W = 10;
    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 17;
    localparam int MASK_W     = 4;
    localparam int CFG_W      = 16;

    localparam logic [CAPTURE_W-1:0] HALF_RANGE = 16'h8000;

    localparam logic [1:0] CMD_CAPTURE  = 2'd0;
    localparam logic [1:0] CMD_OVERFLOW = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    localparam logic REG_TICK_INCREMENT = 1'b0;
    localparam logic REG_TIMEOUT_LIMIT  = 1'b1;

    // one accepted transaction as seen by the watchdog block
    typedef struct packed {
        logic            capture;
        logic            tick;
        logic [CH_W-1:0] channel;
    } watch_req_t;

endpackage

// File: hw/rtl/multi_channel_period_meter.sv
// Top level of the multi-channel period meter.
// Takes one transaction per cycle unless the result side stalls, and returns exactly
// one result per transaction from its output register. Captures form a 32-bit
// stamp from the software high word and the captured count; the previous stamp of
// each channel lives in a small memory that is read and rewritten in the accept
// cycle, the difference being taken in the following stage, so captures on the same
// channel may follow each other in consecutive cycles. Watchdog counters for all
// channels advance in parallel on a tick. Configuration writes go through cfg_wr_en
// and take effect on the next transaction.
`timescale 1ns / 1ps

module multi_channel_period_meter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [pmet_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic [pmet_pkg::CH_W-1:0]        s_channel,
    input  logic [pmet_pkg::CAPTURE_W-1:0]   s_capture_value,
    input  logic                             s_overflow_flag,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pmet_pkg::CH_W-1:0]        m_result_channel,
    output logic [pmet_pkg::STAMP_W-1:0]     m_period,
    output logic                             m_period_valid,
    output logic [pmet_pkg::MASK_W-1:0]      m_timeout_mask,
    output logic                             m_overflow_absorbed
);
    import pmet_pkg::*;

    logic [TICK_INC_W-1:0] tick_increment_reg;
    logic [LIMIT_W-1:0]    timeout_limit_reg;
    logic [15:0]           high_word_reg;
    logic [15:0]           high_word_next;

    logic                  accept;
    logic                  in_range;
    logic                  is_capture;
    logic                  absorb;
    logic [STAMP_W-1:0]    stamp;
    watch_req_t            watch_req;
    logic                  armed_hit;
    logic [MASK_W-1:0]     timeout_mask;
    logic [STAMP_W-1:0]    prev_stamp;

    logic                  s1_valid_reg;
    logic [CH_W-1:0]       s1_channel_reg;
    logic                  s1_period_valid_reg;
    logic [STAMP_W-1:0]    s1_stamp_reg;
    logic [MASK_W-1:0]     s1_mask_reg;
    logic                  s1_absorbed_reg;
    logic                  out_ready;

    logic                  m_valid_reg;
    logic [CH_W-1:0]       m_result_channel_reg;
    logic [STAMP_W-1:0]    m_period_reg;
    logic                  m_period_valid_reg;
    logic [MASK_W-1:0]     m_timeout_mask_reg;
    logic                  m_overflow_absorbed_reg;

    // handshake chain
    assign out_ready = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || out_ready;
    assign accept    = s_valid && s_ready;

    // front stage: stamp forming and high word
    assign in_range   = int'(s_channel) < CHANNEL_COUNT;
    assign is_capture = (s_command == CMD_CAPTURE) && in_range;
    assign absorb     = is_capture && s_overflow_flag && (s_capture_value < HALF_RANGE);
    assign stamp      = {high_word_reg + 16'(absorb), s_capture_value};

    always_comb begin
        high_word_next = high_word_reg;
        if (accept && (absorb || s_command == CMD_OVERFLOW)) begin
            high_word_next = high_word_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_increment_reg <= TICK_INC_W'(10);
            timeout_limit_reg  <= LIMIT_W'(1000);
            high_word_reg      <= '0;
        end else begin
            high_word_reg <= high_word_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TICK_INCREMENT: tick_increment_reg <= cfg_wdata[TICK_INC_W-1:0];
                    REG_TIMEOUT_LIMIT:  timeout_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign watch_req.capture = accept && is_capture;
    assign watch_req.tick    = accept && (s_command == CMD_TICK);
    assign watch_req.channel = s_channel;

    pmet_watch u_watch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (watch_req),
        .tick_increment (tick_increment_reg),
        .timeout_limit  (timeout_limit_reg),
        .armed_hit      (armed_hit),
        .timeout_mask   (timeout_mask)
    );

    pmet_stamp_ram u_stamp_ram (
        .aclk    (aclk),
        .wr_en   (accept && is_capture),
        .wr_addr (s_channel),
        .wr_data (stamp),
        .rd_en   (accept && is_capture),
        .rd_addr (s_channel),
        .rd_data (prev_stamp)
    );

    // second stage: waits for the memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (out_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_channel_reg      <= (s_command == CMD_CAPTURE) ? s_channel : '0;
            s1_period_valid_reg <= is_capture && armed_hit;
            s1_stamp_reg        <= stamp;
            s1_mask_reg         <= timeout_mask;
            s1_absorbed_reg     <= absorb;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            m_result_channel_reg    <= s1_channel_reg;
            m_period_reg            <= s1_period_valid_reg ? (s1_stamp_reg - prev_stamp) : '0;
            m_period_valid_reg      <= s1_period_valid_reg;
            m_timeout_mask_reg      <= s1_mask_reg;
            m_overflow_absorbed_reg <= s1_absorbed_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_result_channel    = m_result_channel_reg;
    assign m_period            = m_period_reg;
    assign m_period_valid      = m_period_valid_reg;
    assign m_timeout_mask      = m_timeout_mask_reg;
    assign m_overflow_absorbed = m_overflow_absorbed_reg;

    a_s1_holds_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_ready) |=> (s1_valid_reg && $stable(s1_stamp_reg)))
        else $error("second stage lost its transaction while blocked");

    a_period_excludes_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_period_valid || m_overflow_absorbed)) |-> (m_timeout_mask == '0))
        else $error("capture result carries a timeout mask");

    a_high_word_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> (high_word_reg == $past(high_word_reg)))
        else $error("high word moved without a transaction");

    a_invalid_period_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_period_valid) |-> (m_period == '0))
        else $error("nonzero period without period_valid");

endmodule

// File: hw/rtl/pmet_stamp_ram.sv
// Last-timestamp memory: one write port, one registered read port.
`timescale 1ns / 1ps

module pmet_stamp_ram (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [pmet_pkg::CH_W-1:0]      wr_addr,
    input  logic [pmet_pkg::STAMP_W-1:0]   wr_data,
    input  logic                           rd_en,
    input  logic [pmet_pkg::CH_W-1:0]      rd_addr,
    output logic [pmet_pkg::STAMP_W-1:0]   rd_data
);
    import pmet_pkg::*;

    logic [STAMP_W-1:0] mem [0:(1 << CH_W)-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write: a same-cycle read returns the old entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/pmet_watch.sv
// Per-channel arm flags and watchdog counters with timeout detection.
`timescale 1ns / 1ps

module pmet_watch (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pmet_pkg::watch_req_t             req,
    input  logic [pmet_pkg::TICK_INC_W-1:0]  tick_increment,
    input  logic [pmet_pkg::LIMIT_W-1:0]     timeout_limit,
    output logic                             armed_hit,
    output logic [pmet_pkg::MASK_W-1:0]      timeout_mask
);
    import pmet_pkg::*;

    logic [CHANNEL_COUNT-1:0] armed_reg;
    logic [CHANNEL_COUNT-1:0] armed_next;
    logic [CHANNEL_COUNT-1:0] watch_en_reg;
    logic [CHANNEL_COUNT-1:0] watch_en_next;
    logic [COUNT_W-1:0]       watch_count_reg  [CHANNEL_COUNT];
    logic [COUNT_W-1:0]       watch_count_next [CHANNEL_COUNT];
    logic [COUNT_W-1:0]       sum;

    always_comb begin
        armed_next    = armed_reg;
        watch_en_next = watch_en_reg;
        timeout_mask  = '0;
        armed_hit     = 1'b0;
        sum           = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            watch_count_next[i] = watch_count_reg[i];
            if (req.capture && i == int'(req.channel)) begin
                armed_hit           = armed_reg[i];
                armed_next[i]       = 1'b1;
                watch_en_next[i]    = 1'b1;
                watch_count_next[i] = '0;
            end
            if (req.tick && watch_en_reg[i]) begin
                sum = watch_count_reg[i] + COUNT_W'(tick_increment);
                if (sum >= COUNT_W'(timeout_limit)) begin
                    armed_next[i]       = 1'b0;
                    watch_en_next[i]    = 1'b0;
                    watch_count_next[i] = '0;
                    if (i < MASK_W) begin
                        timeout_mask[i] = 1'b1;
                    end
                end else begin
                    watch_count_next[i] = sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg    <= '0;
            watch_en_reg <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                watch_count_reg[i] <= '0;
            end
        end else begin
            armed_reg    <= armed_next;
            watch_en_reg <= watch_en_next;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                watch_count_reg[i] <= watch_count_next[i];
            end
        end
    end

    a_armed_matches_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg == watch_en_reg)
        else $error("arm flags and watchdog enables disagree");

    a_timeout_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (timeout_mask != '0) |-> req.tick)
        else $error("timeout reported outside a watchdog tick");

    a_capture_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.capture && !req.tick) |=> armed_reg[$past(req.channel)])
        else $error("capture did not arm its channel");

endmodule

// File: dv/tb_multi_channel_period_meter.sv
// Testbench for the multi-channel period meter: result scoreboard and stimulus.
`timescale 1ns / 1ps

import pmet_pkg::*;

typedef struct {
    logic [CH_W-1:0]    chan;
    logic [STAMP_W-1:0] period;
    logic               period_valid;
    logic [MASK_W-1:0]  mask;
    logic               absorbed;
} period_result_t;

// Tracks timer extension, channel stamps and watchdogs; queues the result of
// every accepted transaction and checks the block's results against it.
class period_tracker;
    bit [15:0]        high_word = '0;
    bit [STAMP_W-1:0] prev_stamp [CHANNEL_COUNT];
    bit               armed [CHANNEL_COUNT];
    bit               watching [CHANNEL_COUNT];
    bit [COUNT_W-1:0] watch_count [CHANNEL_COUNT];
    bit [TICK_INC_W-1:0] tick_inc = 10;
    bit [LIMIT_W-1:0]    limit = 1000;
    period_result_t   pending_results [$];
    int               errors = 0;

    function void set_reg(logic idx, logic [CFG_W-1:0] data);
        if (idx == REG_TICK_INCREMENT) begin
            tick_inc = data[TICK_INC_W-1:0];
        end else begin
            limit = data[LIMIT_W-1:0];
        end
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    function void take_event(logic [1:0] cmd, logic [CH_W-1:0] ch,
                             logic [CAPTURE_W-1:0] cap, logic ovf);
        period_result_t   r;
        bit [STAMP_W-1:0] stamp;
        r = '{chan: '0, period: '0, period_valid: 1'b0, mask: '0, absorbed: 1'b0};
        case (cmd)
            CMD_CAPTURE: begin
                r.chan = ch;
                if (int'(ch) < CHANNEL_COUNT) begin
                    // pending overflow belongs to this capture only below half range
                    if (ovf && cap < HALF_RANGE) begin
                        high_word++;
                        r.absorbed = 1'b1;
                    end
                    stamp = {high_word, cap};
                    if (armed[ch]) begin
                        r.period = stamp - prev_stamp[ch];
                        r.period_valid = 1'b1;
                    end
                    prev_stamp[ch] = stamp;
                    armed[ch] = 1'b1;
                    watch_count[ch] = '0;
                    watching[ch] = 1'b1;
                end
            end
            CMD_OVERFLOW: begin
                high_word++;
            end
            CMD_TICK: begin
                for (int i = 0; i < CHANNEL_COUNT; i++) begin
                    if (watching[i]) begin
                        watch_count[i] = watch_count[i] + COUNT_W'(tick_inc);
                        if (watch_count[i] >= COUNT_W'(limit)) begin
                            armed[i] = 1'b0;
                            watching[i] = 1'b0;
                            prev_stamp[i] = '0;
                            watch_count[i] = '0;
                            if (i < MASK_W) r.mask[i] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        pending_results.push_back(r);
    endfunction

    function void compare_result(logic [CH_W-1:0] chan, logic [STAMP_W-1:0] period,
                                 logic pvalid, logic [MASK_W-1:0] mask, logic absorbed);
        period_result_t exp_r;
        if (pending_results.size() == 0) begin
            $error("result with no transaction outstanding");
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (chan !== exp_r.chan) begin
            $error("result_channel: expected %0d, got %0d", exp_r.chan, chan);
            errors++;
        end
        if (period !== exp_r.period) begin
            $error("period: expected 0x%08h, got 0x%08h", exp_r.period, period);
            errors++;
        end
        if (pvalid !== exp_r.period_valid) begin
            $error("period_valid: expected %0d, got %0d", exp_r.period_valid, pvalid);
            errors++;
        end
        if (mask !== exp_r.mask) begin
            $error("timeout_mask: expected 0x%0h, got 0x%0h", exp_r.mask, mask);
            errors++;
        end
        if (absorbed !== exp_r.absorbed) begin
            $error("overflow_absorbed: expected %0d, got %0d", exp_r.absorbed, absorbed);
            errors++;
        end
    endfunction
endclass

module tb_multi_channel_period_meter;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 1000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_command = '0;
    logic [CH_W-1:0]      s_channel = '0;
    logic [CAPTURE_W-1:0] s_capture_value = '0;
    logic                 s_overflow_flag = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CH_W-1:0]      m_result_channel;
    logic [STAMP_W-1:0]   m_period;
    logic                 m_period_valid;
    logic [MASK_W-1:0]    m_timeout_mask;
    logic                 m_overflow_absorbed;

    period_tracker tracker;
    int            quiet_cycles = 0;
    int            ready_left = 0;

    multi_channel_period_meter DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_channel           (s_channel),
        .s_capture_value     (s_capture_value),
        .s_overflow_flag     (s_overflow_flag),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_channel    (m_result_channel),
        .m_period            (m_period),
        .m_period_valid      (m_period_valid),
        .m_timeout_mask      (m_timeout_mask),
        .m_overflow_absorbed (m_overflow_absorbed)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // receiver: long ready runs, short stalls, and choppy stretches
    always @(negedge aclk) begin
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready <= 1'b1;
                    ready_left = $urandom_range(20, 60);
                end
                1: begin
                    m_ready <= 1'b0;
                    ready_left = $urandom_range(0, 5);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 1) == 1);
                    ready_left = $urandom_range(0, 3);
                end
            endcase
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) tracker.set_reg(cfg_index, cfg_wdata);
            quiet_cycles++;
            if (s_valid && s_ready) begin
                tracker.take_event(s_command, s_channel, s_capture_value, s_overflow_flag);
                quiet_cycles = 0;
            end
            if (m_valid && m_ready) begin
                tracker.compare_result(m_result_channel, m_period, m_period_valid,
                                       m_timeout_mask, m_overflow_absorbed);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_event(logic [1:0] cmd, logic [CH_W-1:0] ch,
                              logic [CAPTURE_W-1:0] cap, logic ovf);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_channel <= ch;
        s_capture_value <= cap;
        s_overflow_flag <= ovf;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_regs(logic [TICK_INC_W-1:0] inc, logic [LIMIT_W-1:0] lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TICK_INCREMENT;
        cfg_wdata <= CFG_W'(inc);
        @(negedge aclk);
        cfg_index <= REG_TIMEOUT_LIMIT;
        cfg_wdata <= lim;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [CAPTURE_W-1:0] pick_capture();
        case ($urandom_range(0, 4))
            0: return CAPTURE_W'($urandom_range(0, 15));
            1: return CAPTURE_W'($urandom_range(16'h7FF8, 16'h8007));
            2: return CAPTURE_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return CAPTURE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic random_event();
        logic [1:0] cmd;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) cmd = CMD_CAPTURE;
        else if (roll < 64) cmd = CMD_OVERFLOW;
        else if (roll < 94) cmd = CMD_TICK;
        else cmd = CMD_UNUSED;
        send_event(cmd, CH_W'($urandom_range(0, 3)), pick_capture(),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(int count, bit gaps);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < count) begin
                random_event();
                sent++;
                burst--;
            end
            if (gaps) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    endtask

    // new register setting: arm every channel, tick once, recapture, then random
    task automatic run_phase(logic [TICK_INC_W-1:0] inc, logic [LIMIT_W-1:0] lim,
                             int count, bit gaps);
        drain();
        write_regs(inc, lim);
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            send_event(CMD_CAPTURE, CH_W'(c), pick_capture(), 1'b0);
        end
        send_event(CMD_TICK, '0, '0, 1'b0);
        send_event(CMD_CAPTURE, '0, pick_capture(), 1'b0);
        run_random(count, gaps);
    endtask

    task automatic directed_part();
        send_event(CMD_TICK, 2'd3, 16'hFFFF, 1'b1);      // nothing armed yet
        send_event(CMD_CAPTURE, 2'd0, 16'h0000, 1'b0);   // arming
        send_event(CMD_CAPTURE, 2'd0, 16'hFFFF, 1'b0);
        send_event(CMD_CAPTURE, 2'd1, 16'h7FFF, 1'b1);   // absorbs overflow
        send_event(CMD_CAPTURE, 2'd1, 16'h8000, 1'b1);   // at half range: not absorbed
        send_event(CMD_OVERFLOW, 2'd2, 16'h1234, 1'b1);
        send_event(CMD_CAPTURE, 2'd2, 16'h0000, 1'b1);
        send_event(CMD_CAPTURE, 2'd3, 16'hFFFF, 1'b1);
        send_event(CMD_UNUSED, 2'd3, 16'hFFFF, 1'b1);
        send_event(CMD_CAPTURE, 2'd0, 16'h0000, 1'b0);
        send_event(CMD_CAPTURE, 2'd3, 16'h0000, 1'b0);   // stamp went backwards
        send_event(CMD_CAPTURE, 2'd2, 16'h0000, 1'b0);   // zero period
        send_event(CMD_UNUSED, 2'd0, 16'h0000, 1'b0);
        send_event(CMD_TICK, 2'd0, 16'h0000, 1'b0);
    endtask

    // a run of back-to-back overflows between two captures on the same channels
    task automatic wrap_high_word();
        drain();
        write_regs(10'd0, 16'd1000);
        send_event(CMD_CAPTURE, 2'd1, 16'h4000, 1'b0);
        send_event(CMD_CAPTURE, 2'd0, 16'h0010, 1'b0);
        repeat (40) send_event(CMD_OVERFLOW, '0, '0, 1'b0);
        send_event(CMD_CAPTURE, 2'd0, 16'h0020, 1'b1);
        send_event(CMD_CAPTURE, 2'd1, 16'h4000, 1'b0);
        send_event(CMD_TICK, '0, '0, 1'b0);
    endtask

    initial begin
        tracker = new;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_part();
        run_random(150, 1'b1);
        run_phase(10'd1, 16'd1, 150, 1'b1);
        run_phase(10'd0, 16'd0, 130, 1'b1);
        run_phase(10'd1023, 16'd65535, 170, 1'b0);
        run_phase(10'd0, 16'd1000, 110, 1'b1);
        run_phase(10'd250, 16'd1000, 160, 1'b1);
        run_phase(10'd1000, 16'd60000, 150, 1'b1);
        run_phase(TICK_INC_W'($urandom_range(1, 400)), LIMIT_W'($urandom_range(1, 3000)),
                  150, 1'b1);
        wrap_high_word();

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
